// ----- design/nfss_pkg.sv -----
// Package for the nearest-first stream scheduler: payload structs, codes,
// controller states and the controller/datapath command and status structs.
// No dependencies.
package nfss_pkg;

  localparam int unsigned TableDepthDefault     = 64;
  localparam int unsigned ResidentLevelsDefault = 8;
  localparam int unsigned CapFactorLog2         = 2;
  localparam logic [31:0] BudgetResetValue      = 32'd8388608;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_LEN  = 2'd1,
    OP_TICK = 2'd2,
    OP_PULL = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [15:0]        texture_index;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic               has_centroid;
    logic [2:0]         level_index;
    logic [31:0]        level_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] granted_texture;
    logic [2:0]  granted_level;
    logic [31:0] granted_length;
    logic        job_finished;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DIST,
    S_PICK,
    S_READ,
    S_DATA,
    S_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;     // latch input item
    logic exec_simple; // add / set length / tick / pull reject
    logic scan_start;  // reset scan pointer and best
    logic scan_step;   // issue read of scan slot
    logic dist_step;   // fold distance of read slot
    logic pick;        // issue reads for the best slot
    logic grant;       // build grant, update table and budget
    logic out_load;    // load result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_pull;
    logic pull_reject; // zero budget or empty table
    logic scan_last;   // compare of the last slot has drained
  } stat_t;

endpackage

// ----- design/nearest_first_stream_scheduler_unit.sv -----
// Top level of the nearest-first stream scheduler: controller and datapath.
// Depends on nfss_pkg, nfss_ctrl, nfss_dpath, nfss_ram.
//
// One item at a time. Add, set-length and tick items are executed in S_SCAN,
// which loads their result. A pull reads every table slot through the
// entry RAM's single read port and a two-stage square/compare pipe, then
// reads the picked job and its level length. The result stays in an output
// register until its transfer; the next item is taken in the cycle after.
module nearest_first_stream_scheduler_unit #(
  parameter int unsigned TABLE_DEPTH     = nfss_pkg::TableDepthDefault,
  parameter int unsigned RESIDENT_LEVELS = nfss_pkg::ResidentLevelsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  nfss_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output nfss_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i
);

  nfss_pkg::cmd_t  cmd;
  nfss_pkg::stat_t stat;
  logic [34:0] budget;
  logic [TABLE_DEPTH-1:0] valid;

  nfss_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  nfss_dpath #(.TableDepth(TABLE_DEPTH), .ResidentLevels(RESIDENT_LEVELS)) u_dpath (
    .clk_i, .rst_ni, .in_data_i, .cfg_we_i, .cfg_wdata_i,
    .cmd_i(cmd), .stat_o(stat), .out_data_o, .budget_o(budget), .valid_o(valid)
  );

  a_grant_spends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.grant |=> (budget <= $past(budget))) else $error("grant raised budget");

  a_grant_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.grant |-> (valid != '0)) else $error("grant from an empty table");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("accept while result pending");

  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.grant |=> (out_valid_o && out_data_o.status == nfss_pkg::ST_OK))
    else $error("grant status");

endmodule

// ----- design/nfss_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module nfss_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- design/nfss_ctrl.sv -----
// Controller state machine of the scheduler: sequences item capture, the
// nearest-job scan and the grant. Depends on nfss_pkg.
module nfss_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  nfss_pkg::stat_t stat_i,
  output nfss_pkg::cmd_t  cmd_o
);

  nfss_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nfss_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // S_IDLE takes an item; S_OUT holds the result until its transfer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nfss_pkg::S_IDLE: begin
        if (in_valid_i) state_d = nfss_pkg::S_SCAN;
      end
      nfss_pkg::S_SCAN: begin
        if (!stat_i.is_pull) state_d = nfss_pkg::S_OUT;
        else state_d = nfss_pkg::S_DIST;
      end
      nfss_pkg::S_DIST: begin
        if (stat_i.scan_last) state_d = nfss_pkg::S_PICK;
      end
      nfss_pkg::S_PICK: begin
        if (stat_i.pull_reject) state_d = nfss_pkg::S_OUT;
        else state_d = nfss_pkg::S_READ;
      end
      nfss_pkg::S_READ: state_d = nfss_pkg::S_DATA;
      nfss_pkg::S_DATA: state_d = nfss_pkg::S_OUT;
      nfss_pkg::S_OUT: begin
        if (out_ready_i) state_d = nfss_pkg::S_IDLE;
      end
      default: state_d = nfss_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      nfss_pkg::S_IDLE: begin
        in_ready_o        = 1'b1;
        cmd_o.capture     = in_valid_i;
        cmd_o.scan_start  = in_valid_i;
      end
      nfss_pkg::S_SCAN: begin
        cmd_o.exec_simple = !stat_i.is_pull;
        cmd_o.out_load    = !stat_i.is_pull;
        cmd_o.scan_step   = stat_i.is_pull;
      end
      nfss_pkg::S_DIST: begin
        cmd_o.dist_step = 1'b1;
        cmd_o.scan_step = !stat_i.scan_last;
      end
      nfss_pkg::S_PICK: begin
        cmd_o.pick        = !stat_i.pull_reject;
        cmd_o.exec_simple = stat_i.pull_reject;
        cmd_o.out_load    = stat_i.pull_reject;
      end
      // keep the entry read on the picked slot so its data is there at grant
      nfss_pkg::S_READ: cmd_o.pick = 1'b1;
      nfss_pkg::S_DATA: begin
        cmd_o.grant    = 1'b1;
        cmd_o.out_load = 1'b1;
      end
      nfss_pkg::S_OUT: out_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule

// ----- design/nfss_dpath.sv -----
// Datapath of the scheduler: job table memories, valid bits, budget, camera,
// scan pointer, distance unit and result register. Depends on nfss_pkg, nfss_ram.
module nfss_dpath #(
  parameter int unsigned TableDepth     = nfss_pkg::TableDepthDefault,
  parameter int unsigned ResidentLevels = nfss_pkg::ResidentLevelsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nfss_pkg::in_item_t  in_data_i,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  input  nfss_pkg::cmd_t      cmd_i,
  output nfss_pkg::stat_t     stat_o,
  output nfss_pkg::out_item_t out_data_o,
  output logic [34:0]         budget_o,
  output logic [TableDepth-1:0] valid_o
);

  localparam int unsigned SlotW = $clog2(TableDepth);
  localparam int unsigned LvlW  = (ResidentLevels > 1) ? $clog2(ResidentLevels) : 1;
  localparam int unsigned LenAw = $clog2(TableDepth * ResidentLevels);
  // entry word: texture, x, y, z, has_centroid
  localparam int unsigned EntW  = 16 + 72 + 1;

  nfss_pkg::in_item_t  item_q;
  nfss_pkg::out_item_t out_q, out_d;
  logic [TableDepth-1:0] valid_q;
  logic [34:0] budget_q, budget_d;
  logic [31:0] per_frame_q;
  logic signed [23:0] cam_x_q, cam_y_q, cam_z_q;
  logic [SlotW-1:0] last_slot_q;
  logic [SlotW-1:0] ptr_q, rd_slot_q, best_q;
  logic best_found_q, best_far_q;
  logic [49:0] best_d_q;
  logic rd_vld_q;

  // free slot search (priority encoder over valid bits)
  logic [SlotW-1:0] free_slot;
  logic             has_free;
  always_comb begin
    free_slot = '0;
    has_free  = 1'b0;
    for (int i = TableDepth - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_slot = SlotW'(i);
        has_free  = 1'b1;
      end
    end
  end

  logic [2:0] add_lvl;
  assign add_lvl = (32'(item_q.level_index) >= ResidentLevels)
                   ? 3'(ResidentLevels - 1) : item_q.level_index;

  nfss_pkg::op_e op;
  assign op = nfss_pkg::op_e'(item_q.operation);

  // entry memory
  logic             ent_we;
  logic [SlotW-1:0] ent_raddr;
  logic [EntW-1:0]  ent_wdata, ent_rdata;
  assign ent_we    = cmd_i.exec_simple && op == nfss_pkg::OP_ADD && has_free;
  assign ent_wdata = {item_q.texture_index, item_q.pos_x, item_q.pos_y,
                      item_q.pos_z, item_q.has_centroid};
  assign ent_raddr = cmd_i.pick ? best_q : ptr_q;

  nfss_ram #(.Width(EntW), .Depth(TableDepth)) u_ent (
    .clk_i, .we_i(ent_we), .waddr_i(free_slot), .wdata_i(ent_wdata),
    .raddr_i(ent_raddr), .rdata_o(ent_rdata)
  );

  // next level memory, read at the best slot; written on add and on a grant of a nonzero level
  logic [2:0]       best_lvl;
  logic             lvl_we;
  logic [SlotW-1:0] lvl_waddr;
  logic [2:0]       lvl_wdata;
  assign lvl_we    = ent_we || (cmd_i.grant && best_lvl != 3'd0);
  assign lvl_waddr = ent_we ? free_slot : best_q;
  assign lvl_wdata = ent_we ? add_lvl : best_lvl - 3'd1;

  nfss_ram #(.Width(3), .Depth(TableDepth)) u_lvl (
    .clk_i, .we_i(lvl_we), .waddr_i(lvl_waddr), .wdata_i(lvl_wdata),
    .raddr_i(best_q), .rdata_o(best_lvl)
  );

  // level length memory
  logic [LvlW-1:0]  best_lvl_n, set_lvl_n;
  logic             len_we;
  logic [LenAw-1:0] len_waddr, len_raddr;
  logic [31:0]      len_rdata;
  assign best_lvl_n = LvlW'(best_lvl);
  assign set_lvl_n  = LvlW'(item_q.level_index);
  assign len_we     = cmd_i.exec_simple && op == nfss_pkg::OP_LEN &&
                      32'(item_q.level_index) < ResidentLevels;
  assign len_waddr  = LenAw'(32'(last_slot_q) * ResidentLevels + 32'(set_lvl_n));
  assign len_raddr  = LenAw'(32'(best_q) * ResidentLevels + 32'(best_lvl_n));

  nfss_ram #(.Width(32), .Depth(TableDepth * ResidentLevels)) u_len (
    .clk_i, .we_i(len_we), .waddr_i(len_waddr), .wdata_i(item_q.level_length),
    .raddr_i(len_raddr), .rdata_o(len_rdata)
  );

  // distance: squares of the three 25-bit differences, registered, then summed
  logic signed [24:0] dx, dy, dz;
  logic [23:0] ax, ay, az;
  logic [47:0] sqx_q, sqy_q, sqz_q;
  logic        sq_vld_q, sq_far_q;
  logic [SlotW-1:0] sq_slot_q;
  logic [49:0] dist_sum;
  logic signed [23:0] ex, ey, ez;
  assign ex = ent_rdata[72:49];
  assign ey = ent_rdata[48:25];
  assign ez = ent_rdata[24:1];
  assign dx = 25'(ex) - 25'(cam_x_q);
  assign dy = 25'(ey) - 25'(cam_y_q);
  assign dz = 25'(ez) - 25'(cam_z_q);
  assign ax = dx[24] ? 24'(-dx) : dx[23:0];
  assign ay = dy[24] ? 24'(-dy) : dy[23:0];
  assign az = dz[24] ? 24'(-dz) : dz[23:0];
  assign dist_sum = 50'(sqx_q) + 50'(sqy_q) + 50'(sqz_q);

  logic better;
  assign better = !best_found_q || (best_far_q && !sq_far_q) ||
                  (!best_far_q && !sq_far_q && dist_sum < best_d_q);

  logic [34:0] cap, sum;
  assign cap = 35'(per_frame_q) << nfss_pkg::CapFactorLog2;
  assign sum = budget_q + 35'(per_frame_q);

  always_comb begin
    budget_d = budget_q;
    out_d    = '0;
    if (cmd_i.exec_simple) begin
      unique case (op)
        nfss_pkg::OP_ADD: out_d.status = has_free ? nfss_pkg::ST_OK : nfss_pkg::ST_FULL;
        nfss_pkg::OP_LEN: out_d.status = nfss_pkg::ST_OK;
        nfss_pkg::OP_TICK: begin
          out_d.status = nfss_pkg::ST_OK;
          budget_d     = (sum > cap) ? cap : sum;
        end
        nfss_pkg::OP_PULL: out_d.status = nfss_pkg::ST_EMPTY;
        default: ;
      endcase
    end
    if (cmd_i.grant) begin
      out_d.status          = nfss_pkg::ST_OK;
      out_d.granted_texture = ent_rdata[88:73];
      out_d.granted_level   = best_lvl;
      out_d.granted_length  = len_rdata;
      out_d.job_finished    = (best_lvl == 3'd0);
      budget_d = (35'(len_rdata) >= budget_q) ? '0 : budget_q - 35'(len_rdata);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      budget_q     <= '0;
      per_frame_q  <= nfss_pkg::BudgetResetValue;
      cam_x_q      <= '0;
      cam_y_q      <= '0;
      cam_z_q      <= '0;
      last_slot_q  <= '0;
      ptr_q        <= '0;
      rd_vld_q     <= 1'b0;
      sq_vld_q     <= 1'b0;
      best_found_q <= 1'b0;
    end else begin
      if (cfg_we_i) per_frame_q <= cfg_wdata_i;
      budget_q <= budget_d;
      if (cmd_i.exec_simple && op == nfss_pkg::OP_TICK) begin
        cam_x_q <= item_q.pos_x;
        cam_y_q <= item_q.pos_y;
        cam_z_q <= item_q.pos_z;
      end
      if (ent_we) begin
        valid_q[free_slot] <= 1'b1;
        last_slot_q        <= free_slot;
      end
      if (cmd_i.grant && best_lvl == 3'd0) valid_q[best_q] <= 1'b0;
      if (cmd_i.scan_start) begin
        ptr_q        <= '0;
        best_found_q <= 1'b0;
        rd_vld_q     <= 1'b0;
        sq_vld_q     <= 1'b0;
      end else begin
        // two-stage scan pipe: read, square, compare
        rd_vld_q <= cmd_i.scan_step && valid_q[ptr_q];
        sq_vld_q <= rd_vld_q;
        if (cmd_i.scan_step) ptr_q <= ptr_q + 1'b1;
        if (sq_vld_q && better) best_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= in_data_i;
    if (cmd_i.scan_step) rd_slot_q <= ptr_q;
    sqx_q     <= ax * ax;
    sqy_q     <= ay * ay;
    sqz_q     <= az * az;
    sq_far_q  <= !ent_rdata[0];
    sq_slot_q <= rd_slot_q;
    if (sq_vld_q && better) begin
      best_q     <= sq_slot_q;
      best_far_q <= sq_far_q;
      best_d_q   <= sq_far_q ? '0 : dist_sum;
    end
    if (cmd_i.out_load) out_q <= out_d;
  end

  // scan ends after the compare of the last slot has drained
  logic [SlotW+1:0] drain_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) drain_q <= '0;
    else if (cmd_i.scan_start) drain_q <= '0;
    else if (cmd_i.dist_step) drain_q <= drain_q + 1'b1;
  end

  assign stat_o.is_pull     = op == nfss_pkg::OP_PULL;
  assign stat_o.scan_last   = 32'(drain_q) == TableDepth + 1;
  assign stat_o.pull_reject = budget_q == '0 || !best_found_q;
  assign out_data_o = out_q;
  assign budget_o   = budget_q;
  assign valid_o    = valid_q;

endmodule

// ----- sim/nfss_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the nearest-first stream scheduler: keeps its own copy of the
// job table, budget and camera, predicts every result and compares it.
// Depends on nfss_pkg.
module nfss_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  nfss_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  nfss_pkg::out_item_t out_data_i,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  output int                  fail_count_o,
  output int                  grants_seen_o
);

  localparam int Slots  = 64;
  localparam int Levels = 8;
  localparam int ExpDepth = 16;

  logic               job_live   [Slots];
  logic [15:0]        job_tex    [Slots];
  logic signed [23:0] job_cx     [Slots];
  logic signed [23:0] job_cy     [Slots];
  logic signed [23:0] job_cz     [Slots];
  logic               job_has_c  [Slots];
  logic [2:0]         job_level  [Slots];
  logic [31:0]        level_bytes[Slots*Levels];
  logic [63:0]        budget;
  logic signed [23:0] cam_x, cam_y, cam_z;
  int                 newest_slot;
  logic [31:0]        frame_budget;

  nfss_pkg::out_item_t exp_fifo[ExpDepth];
  int        exp_wr, exp_rd;
  int        fail_count;
  int        grants_seen;

  assign fail_count_o  = fail_count;
  assign grants_seen_o = grants_seen;

  function automatic longint unsigned axis_sq(logic signed [23:0] a, logic signed [23:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return longint'(d * d);
  endfunction

  function automatic nfss_pkg::out_item_t schedule_step(nfss_pkg::in_item_t it);
    nfss_pkg::out_item_t res;
    int                slot;
    int                best;
    logic              found, best_far, far;
    longint unsigned   sq_dist, best_dist;
    logic [63:0]       cap;
    logic [2:0]        lvl;
    logic [31:0]       len;
    res  = '0;
    slot = -1;
    case (nfss_pkg::op_e'(it.operation))
      nfss_pkg::OP_ADD: begin
        for (int i = 0; i < Slots; i++) begin
          if (!job_live[i] && slot < 0) slot = i;
        end
        if (slot < 0) begin
          res.status = nfss_pkg::ST_FULL;
        end else begin
          job_live[slot]  = 1'b1;
          job_tex[slot]   = it.texture_index;
          job_cx[slot]    = it.pos_x;
          job_cy[slot]    = it.pos_y;
          job_cz[slot]    = it.pos_z;
          job_has_c[slot] = it.has_centroid;
          job_level[slot] = it.level_index;
          newest_slot     = slot;
        end
      end
      nfss_pkg::OP_LEN: level_bytes[newest_slot*Levels + it.level_index] = it.level_length;
      nfss_pkg::OP_TICK: begin
        cap    = {32'd0, frame_budget} << nfss_pkg::CapFactorLog2;
        cam_x  = it.pos_x;
        cam_y  = it.pos_y;
        cam_z  = it.pos_z;
        budget = budget + frame_budget;
        if (budget > cap) budget = cap;
      end
      default: begin
        found     = 1'b0;
        best_far  = 1'b0;
        best_dist = 0;
        best      = 0;
        if (budget != 0) begin
          for (int i = 0; i < Slots; i++) begin
            if (job_live[i]) begin
              far     = !job_has_c[i];
              sq_dist = far ? 0 : axis_sq(job_cx[i], cam_x) + axis_sq(job_cy[i], cam_y)
                                  + axis_sq(job_cz[i], cam_z);
              // centroid-less jobs rank last; strict compare keeps lowest slot on ties
              if (!found || (best_far && !far) ||
                  (!far && !best_far && sq_dist < best_dist)) begin
                found     = 1'b1;
                best      = i;
                best_far  = far;
                best_dist = sq_dist;
              end
            end
          end
        end
        if (!found) begin
          res.status = nfss_pkg::ST_EMPTY;
        end else begin
          lvl = job_level[best];
          len = level_bytes[best*Levels + lvl];
          res.status          = nfss_pkg::ST_OK;
          res.granted_texture = job_tex[best];
          res.granted_level   = lvl;
          res.granted_length  = len;
          if (lvl == 0) begin
            job_live[best]   = 1'b0;
            res.job_finished = 1'b1;
          end else begin
            job_level[best] = lvl - 1;
          end
          if ({32'd0, len} >= budget) budget = 0;
          else budget = budget - len;
        end
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    nfss_pkg::out_item_t exp_res;
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) job_live[i] = 1'b0;
      budget         = 0;
      cam_x          = 0;
      cam_y          = 0;
      cam_z          = 0;
      newest_slot    = 0;
      frame_budget   = nfss_pkg::BudgetResetValue;
      fail_count     = 0;
      grants_seen    = 0;
      exp_wr         = 0;
      exp_rd         = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        grants_seen++;
        if (exp_wr == exp_rd) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result transfer: %p", out_data_i);
        end else begin
          exp_res = exp_fifo[exp_rd % ExpDepth];
          exp_rd++;
          if (out_data_i.status !== exp_res.status
              || out_data_i.granted_texture !== exp_res.granted_texture
              || out_data_i.granted_level !== exp_res.granted_level
              || out_data_i.granted_length !== exp_res.granted_length
              || out_data_i.job_finished !== exp_res.job_finished) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected %p actual %p", exp_res, out_data_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        exp_fifo[exp_wr % ExpDepth] = schedule_step(in_data_i);
        exp_wr++;
      end
      if (cfg_we_i) frame_budget = cfg_wdata_i;
    end
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Stimulus and verdict for the nearest-first stream scheduler.
// Depends on nfss_pkg, nearest_first_stream_scheduler_unit and nfss_checker.
module tb_top;

  localparam int CycleLimit = 1000000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  nfss_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  nfss_pkg::out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  int fail_count, grants_seen;
  int items_sent = 0;
  int cycle_count = 0;
  logic long_hold = 1'b0;
  logic no_gaps = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  nearest_first_stream_scheduler_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  nfss_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .grants_seen_o(grants_seen)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off that backs up the block
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (600) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!(out_valid && out_ready));
    end
  end

  task automatic send(nfss_pkg::in_item_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (!(in_valid && in_ready));
    items_sent++;
  endtask

  function automatic nfss_pkg::in_item_t mk(nfss_pkg::op_e op, logic [31:0] tex,
                                            logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                            logic [31:0] hc, logic [31:0] lvl,
                                            logic [31:0] len);
    nfss_pkg::in_item_t it;
    it.operation     = op;
    it.texture_index = tex[15:0];
    it.pos_x         = x[23:0];
    it.pos_y         = y[23:0];
    it.pos_z         = z[23:0];
    it.has_centroid  = hc[0];
    it.level_index   = lvl[2:0];
    it.level_length  = len;
    return it;
  endfunction

  function automatic logic [31:0] rand_len();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom();
      default: return $urandom_range(0, 4000000);
    endcase
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 5))
      0:       return 32'h007F_FFFF;
      1:       return 32'h0080_0000;
      2:       return $urandom_range(0, 255);
      default: return $urandom();
    endcase
  endfunction

  // add followed by a length for every level it will ever grant
  task automatic add_job(logic [31:0] tex, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                         logic [31:0] hc, logic [31:0] top_lvl, logic [31:0] len);
    send(mk(nfss_pkg::OP_ADD, tex, x, y, z, hc, top_lvl, 32'd0));
    for (int unsigned l = 0; l <= top_lvl; l++)
      send(mk(nfss_pkg::OP_LEN, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
              l, (len == 32'd1) ? rand_len() : len));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (grants_seen != items_sent) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_budget(logic [31:0] val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [31:0] budgets[6];
    int          per_phase;
    int          phase_start;
    int          pick;
    logic        hold_done;
    budgets   = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd8388608, 32'd20000000, 32'd0};
    hold_done = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    send(mk(nfss_pkg::OP_LEN, 0, 0, 0, 0, 0, 32'd5, 32'd77));   // length before any add
    send(mk(nfss_pkg::OP_PULL, 0, 0, 0, 0, 0, 0, 0));           // zero budget
    send(mk(nfss_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    send(mk(nfss_pkg::OP_PULL, 0, 0, 0, 0, 0, 0, 0));           // empty table
    add_job(32'h0000_FFFF, 32'h007F_FFFF, 32'h007F_FFFF, 32'h007F_FFFF, 32'd1, 32'd1,
            32'd1000);
    add_job(32'd0, 32'h0080_0000, 32'h0080_0000, 32'h0080_0000, 32'd1, 32'd0,
            32'hFFFF_FFFF);
    add_job(32'h0000_1234, 32'd5, 32'd5, 32'd5, 32'd0, 32'd0, 32'd10);
    add_job(32'h0000_0042, 32'd256, 32'd0, 32'd0, 32'd1, 32'd0, 32'd20);  // equal distance pair
    add_job(32'h0000_0043, 32'd256, 32'd0, 32'd0, 32'd1, 32'd7, 32'd30);
    send(mk(nfss_pkg::OP_PULL, 0, 0, 0, 0, 0, 0, 0));
    send(mk(nfss_pkg::OP_TICK, 0, 32'h007F_FFFF, 32'h007F_FFFF, 32'h007F_FFFF, 0, 0, 0));
    send(mk(nfss_pkg::OP_PULL, 0, 0, 0, 0, 0, 0, 0));
    send(mk(nfss_pkg::OP_TICK, 0, 32'h0080_0000, 32'h0080_0000, 32'h0080_0000, 0, 0, 0));
    send(mk(nfss_pkg::OP_PULL, 0, 0, 0, 0, 0, 0, 0));           // overdraw drains budget
    send(mk(nfss_pkg::OP_PULL, 0, 0, 0, 0, 0, 0, 0));

    per_phase = 300;
    for (int p = 0; p < 6; p++) begin
      write_budget(p == 5 ? $urandom() : budgets[p]);
      phase_start = items_sent;
      no_gaps     = (p == 3);
      while (items_sent - phase_start < per_phase) begin
        if (p == 2 && !hold_done && items_sent - phase_start >= 100) begin
          long_hold = 1'b1;
          hold_done = 1'b1;
        end
        pick = $urandom_range(0, 99);
        // phases 0 and 1 lean on adds so the table fills up
        if (pick < ((p < 2) ? 55 : 30))
          add_job($urandom(), rand_pos(), rand_pos(), rand_pos(),
                  ($urandom_range(0, 4) != 0) ? 32'd1 : 32'd0,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 2),
                  32'd1);
        else if (pick < 65)
          send(mk(nfss_pkg::OP_PULL, $urandom(), $urandom(), $urandom(), $urandom(),
                  $urandom(), $urandom(), $urandom()));
        else if (pick < 85)
          send(mk(nfss_pkg::OP_TICK, $urandom(), rand_pos(), rand_pos(), rand_pos(),
                  $urandom(), $urandom(), $urandom()));
        else
          send(mk(nfss_pkg::OP_LEN, $urandom(), $urandom(), $urandom(), $urandom(),
                  $urandom(), $urandom(), rand_len()));
      end
    end

    wait_idle();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && grants_seen == items_sent) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- nearest_first_stream_scheduler_unit.f -----
design/nfss_pkg.sv
design/nfss_ram.sv
design/nfss_ctrl.sv
design/nfss_dpath.sv
design/nearest_first_stream_scheduler_unit.sv
sim/nfss_checker.sv
sim/tb_top.sv
